>>> hw/rtl/itaf_pkg.sv
// Shared types, codes and helpers of the integer to ASCII formatter.
package itaf_pkg;

    localparam logic [2:0] MODE_U32 = 3'd0;
    localparam logic [2:0] MODE_S32 = 3'd1;
    localparam logic [2:0] MODE_U64 = 3'd2;
    localparam logic [2:0] MODE_S64 = 3'd3;
    localparam logic [2:0] MODE_HEX = 3'd4;

    localparam int unsigned VALUE_W    = 64;
    localparam int unsigned HEX_DIGITS = 16;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_X     = 8'h78;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_A     = 8'h61;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_PRE0,
        ST_PREX,
        ST_SKIP,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic conv;
        logic skip;
        logic emit;
        logic put_sign;
        logic put_zero;
        logic put_x;
    } t_dp_cmd;

    typedef struct packed {
        logic conv_done;
        logic neg;
        logic top_zero;
        logic one_left;
    } t_dp_sts;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = CHAR_ZERO + {4'd0, d};
        end else begin
            c = CHAR_A + {4'd0, d - 4'd10};
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/itaf_ctrl.sv
// Sequencer of the formatter: conversion, prefix, leading-zero skip and emit phases.
module itaf_ctrl
    import itaf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic [2:0] i_mode,
    input  t_dp_sts    i_sts,
    output t_dp_cmd    o_cmd,
    output logic       busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    case (i_mode)
                        MODE_U32, MODE_S32, MODE_U64, MODE_S64: n_state = ST_CONV;
                        MODE_HEX: n_state = ST_PRE0;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_CONV: begin
                o_cmd.conv = 1'b1;
                if (i_sts.conv_done) begin
                    n_state = i_sts.neg ? ST_SIGN : ST_SKIP;
                end
            end
            ST_SIGN: begin
                o_cmd.put_sign = 1'b1;
                n_state        = ST_SKIP;
            end
            ST_PRE0: begin
                o_cmd.put_zero = 1'b1;
                n_state        = ST_PREX;
            end
            ST_PREX: begin
                o_cmd.put_x = 1'b1;
                n_state     = ST_SKIP;
            end
            ST_SKIP: begin
                // drop leading zeros, but always keep the final digit
                if (i_sts.top_zero && !i_sts.one_left) begin
                    o_cmd.skip = 1'b1;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_sts.one_left) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign busy = (r_state != ST_IDLE);

endmodule

>>> hw/rtl/itaf_dp.sv
// Datapath of the formatter: magnitude, shift-add-3 BCD conversion and character output.
module itaf_dp
    import itaf_pkg::*;
#(
    parameter int unsigned MAX_DIGITS = 20
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [2:0]         i_mode,
    input  logic [VALUE_W-1:0] i_value,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    output logic [7:0]         o_character,
    output logic               o_last,
    output logic               o_strobe
);

    localparam int unsigned DW = MAX_DIGITS * 4;
    localparam int unsigned LW = $clog2(MAX_DIGITS + 1);
    localparam int unsigned CW = $clog2(VALUE_W);

    logic [VALUE_W-1:0] r_bin;
    logic [VALUE_W-1:0] n_bin;
    logic [DW-1:0]      r_dig;
    logic [DW-1:0]      n_dig;
    logic [DW-1:0]      adj;
    logic [LW-1:0]      r_left;
    logic [LW-1:0]      n_left;
    logic [CW-1:0]      r_cnt;
    logic [CW-1:0]      n_cnt;
    logic               r_neg;
    logic               n_neg;
    logic               r_strobe;
    logic               n_strobe;
    logic [7:0]         r_char;
    logic [7:0]         n_char;
    logic               r_last;
    logic               n_last;
    logic [31:0]        lo;
    logic [3:0]         top;

    assign lo  = i_value[31:0];
    assign top = r_dig[DW-1 -: 4];

    // add 3 to every BCD digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < int'(MAX_DIGITS); i++) begin
            adj[4*i +: 4] = (r_dig[4*i +: 4] >= 4'd5) ? r_dig[4*i +: 4] + 4'd3
                                                      : r_dig[4*i +: 4];
        end
    end

    always_comb begin
        n_bin    = r_bin;
        n_dig    = r_dig;
        n_left   = r_left;
        n_cnt    = r_cnt;
        n_neg    = r_neg;
        n_strobe = 1'b0;
        n_char   = r_char;
        n_last   = r_last;
        if (i_cmd.load) begin
            n_dig  = '0;
            n_cnt  = '0;
            n_neg  = 1'b0;
            n_left = LW'(MAX_DIGITS);
            case (i_mode)
                MODE_U32: n_bin = {32'd0, lo};
                MODE_S32: begin
                    n_neg = lo[31];
                    n_bin = lo[31] ? {32'd0, 32'd0 - lo} : {32'd0, lo};
                end
                MODE_U64: n_bin = i_value;
                MODE_S64: begin
                    n_neg = i_value[VALUE_W-1];
                    n_bin = i_value[VALUE_W-1] ? VALUE_W'(0) - i_value : i_value;
                end
                MODE_HEX: begin
                    n_bin  = i_value;
                    n_dig  = {i_value, {(DW-VALUE_W){1'b0}}};
                    n_left = LW'(HEX_DIGITS);
                end
                default: n_bin = i_value;
            endcase
        end
        if (i_cmd.conv) begin
            n_dig = {adj[DW-2:0], r_bin[VALUE_W-1]};
            n_bin = {r_bin[VALUE_W-2:0], 1'b0};
            n_cnt = r_cnt + CW'(1);
        end
        if (i_cmd.skip || i_cmd.emit) begin
            n_dig  = {r_dig[DW-5:0], 4'd0};
            n_left = r_left - LW'(1);
        end
        if (i_cmd.emit) begin
            n_strobe = 1'b1;
            n_char   = digit_char(top);
            n_last   = (r_left == LW'(1));
        end
        if (i_cmd.put_sign || i_cmd.put_zero || i_cmd.put_x) begin
            n_strobe = 1'b1;
            n_last   = 1'b0;
            n_char   = i_cmd.put_sign ? CHAR_MINUS : (i_cmd.put_zero ? CHAR_ZERO : CHAR_X);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin  <= n_bin;
        r_dig  <= n_dig;
        r_left <= n_left;
        r_cnt  <= n_cnt;
        r_neg  <= n_neg;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_sts.conv_done = (r_cnt == CW'(VALUE_W - 1));
    assign o_sts.neg       = r_neg;
    assign o_sts.top_zero  = (top == 4'd0);
    assign o_sts.one_left  = (r_left == LW'(1));

    assign o_character = r_char;
    assign o_last      = r_last;
    assign o_strobe    = r_strobe;

endmodule

>>> hw/rtl/integer_to_ascii_formatter.sv
// Decimal modes: busy through the conversion (one bit per cycle), a minus sign for a negative
// value, then the leading-zero skip and the emit of the digits. Hex mode: busy through the
// 0 and x prefix characters, then the leading-zero skip and the emit of the hex digits.
// Each character shows on o_character in the cycle after it is produced, so the final one falls
// in the first idle cycle and start is taken at the earliest on the edge that ends it; a new
// word is taken only while idle. An unused mode emits nothing; the receiver cannot stall.
module integer_to_ascii_formatter
    import itaf_pkg::*;
#(
    parameter int unsigned MAX_DIGITS = 20
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         start,
    input  logic [2:0]   i_mode,
    input  logic [63:0]  i_value,
    output logic         busy,
    output logic [7:0]   o_character,
    output logic         o_last,
    output logic         o_strobe
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    itaf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_mode  (i_mode),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    itaf_dp #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (i_mode),
        .i_value     (i_value),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_character (o_character),
        .o_last      (o_last),
        .o_strobe    (o_strobe)
    );

endmodule
